/* src/sed_pkg.sv */
// ----------------------------------------------------------------------------
// sed_pkg: shared types and constants for the string escape decoder
// Holds the decoder state and result types, the mode codes and the
// character constants used by the escape decode.
// ----------------------------------------------------------------------------
package sed_pkg;

    // Decoder mode, one-hot.
    typedef enum logic [3:0] {
        MODE_PLAIN = 4'b0001,
        MODE_BSL   = 4'b0010,
        MODE_OCT   = 4'b0100,
        MODE_HEX   = 4'b1000
    } mode_t;

    // Input item kinds carried on tuser.
    localparam logic ACT_DATA  = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // Characters with a meaning after a backslash.
    localparam logic [7:0] CHAR_BSL  = 8'h5c;
    localparam logic [7:0] CHAR_X    = 8'h78;
    localparam logic [7:0] CHAR_A    = 8'h61;
    localparam logic [7:0] CHAR_B    = 8'h62;
    localparam logic [7:0] CHAR_T    = 8'h74;
    localparam logic [7:0] CHAR_N    = 8'h6e;
    localparam logic [7:0] CHAR_V    = 8'h76;
    localparam logic [7:0] CHAR_F    = 8'h66;
    localparam logic [7:0] CHAR_R    = 8'h72;
    localparam logic [7:0] CHAR_0    = 8'h30;
    localparam logic [7:0] CHAR_7    = 8'h37;
    localparam logic [7:0] CHAR_9    = 8'h39;
    localparam logic [7:0] CHAR_LA   = 8'h61;
    localparam logic [7:0] CHAR_LF   = 8'h66;
    localparam logic [7:0] CHAR_UA   = 8'h41;
    localparam logic [7:0] CHAR_UF   = 8'h46;

    // Control characters produced by the simple escapes.
    localparam logic [7:0] CODE_BEL  = 8'h07;
    localparam logic [7:0] CODE_BS   = 8'h08;
    localparam logic [7:0] CODE_HT   = 8'h09;
    localparam logic [7:0] CODE_LF   = 8'h0a;
    localparam logic [7:0] CODE_VT   = 8'h0b;
    localparam logic [7:0] CODE_FF   = 8'h0c;
    localparam logic [7:0] CODE_CR   = 8'h0d;

    // Octal escapes end after this many digits; hex keeps this many.
    localparam logic [1:0] OCT_DIGITS = 2'd3;
    localparam logic [1:0] HEX_DIGITS = 2'd2;

    // Output queue depth; an item is decoded only when two slots are free.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Decoder state.
    typedef struct packed {
        mode_t      mode;
        logic [7:0] accum;
        logic [1:0] digit_count;
    } dec_state_t;

    // One result transfer.
    typedef struct packed {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last_of_run;
    } result_t;

endpackage

/* src/sed_decode.sv */
// ----------------------------------------------------------------------------
// sed_decode: escape decode step
// Combinational decode of one input item against the current state:
// gives the next state and up to two result transfers.
// ----------------------------------------------------------------------------
module sed_decode
    import sed_pkg::*;
(
    input  dec_state_t state_cur,
    input  logic       action,
    input  logic [7:0] in_byte,
    output dec_state_t state_nxt,
    output logic [1:0] res_count,
    output result_t    res0,
    output result_t    res1
);

    logic       is_oct;
    logic       is_hex;
    logic [3:0] hex_val;
    logic [7:0] simple_val;
    logic [7:0] pending;
    logic [7:0] oct_accum;
    logic [1:0] oct_count;
    dec_state_t plain_state;

    // Digit classification of the incoming byte.
    always_comb begin
        is_oct  = in_byte inside {[CHAR_0:CHAR_7]};
        is_hex  = 1'b1;
        hex_val = 4'd0;
        if (in_byte inside {[CHAR_0:CHAR_9]}) begin
            hex_val = 4'(in_byte - CHAR_0);
        end else if (in_byte inside {[CHAR_LA:CHAR_LF]}) begin
            hex_val = 4'(in_byte - CHAR_LA + 8'd10);
        end else if (in_byte inside {[CHAR_UA:CHAR_UF]}) begin
            hex_val = 4'(in_byte - CHAR_UA + 8'd10);
        end else begin
            is_hex = 1'b0;
        end
    end

    // Value of a single-character escape; unknown ones give the byte itself.
    always_comb begin
        case (in_byte)
            CHAR_A:  simple_val = CODE_BEL;
            CHAR_B:  simple_val = CODE_BS;
            CHAR_T:  simple_val = CODE_HT;
            CHAR_N:  simple_val = CODE_LF;
            CHAR_V:  simple_val = CODE_VT;
            CHAR_F:  simple_val = CODE_FF;
            CHAR_R:  simple_val = CODE_CR;
            default: simple_val = in_byte;
        endcase
    end

    // A hex escape without digits stands for the letter itself.
    assign pending = ((state_cur.mode == MODE_HEX) && (state_cur.digit_count == 2'd0))
                     ? CHAR_X : state_cur.accum;

    assign oct_accum = {state_cur.accum[4:0], in_byte[2:0]};
    assign oct_count = state_cur.digit_count + 2'd1;

    assign plain_state = '{mode: MODE_PLAIN, accum: 8'd0, digit_count: 2'd0};

    // Main decode.
    always_comb begin
        state_nxt = state_cur;
        res_count = 2'd0;
        res0      = '{out_byte: 8'd0, is_data: 1'b1, last_of_run: 1'b1};
        res1      = '{out_byte: in_byte, is_data: 1'b1, last_of_run: 1'b1};
        if (action == ACT_FLUSH) begin
            // Flush a pending numeric escape, then the terminator.
            state_nxt = plain_state;
            if ((state_cur.mode == MODE_OCT) || (state_cur.mode == MODE_HEX)) begin
                res_count = 2'd2;
                res0      = '{out_byte: pending, is_data: 1'b1, last_of_run: 1'b0};
                res1      = '{out_byte: 8'd0, is_data: 1'b0, last_of_run: 1'b1};
            end else begin
                res_count = 2'd1;
                res0      = '{out_byte: 8'd0, is_data: 1'b0, last_of_run: 1'b1};
            end
        end else begin
            case (state_cur.mode)
                MODE_PLAIN: begin
                    if (in_byte == CHAR_BSL) begin
                        state_nxt.mode = MODE_BSL;
                    end else begin
                        res_count     = 2'd1;
                        res0.out_byte = in_byte;
                    end
                end
                MODE_BSL: begin
                    if (in_byte == CHAR_X) begin
                        state_nxt = '{mode: MODE_HEX, accum: 8'd0, digit_count: 2'd0};
                    end else if (is_oct) begin
                        state_nxt = '{mode: MODE_OCT, accum: {5'd0, in_byte[2:0]},
                                      digit_count: 2'd1};
                    end else begin
                        state_nxt     = plain_state;
                        res_count     = 2'd1;
                        res0.out_byte = simple_val;
                    end
                end
                MODE_OCT: begin
                    if (is_oct) begin
                        if (oct_count == OCT_DIGITS) begin
                            state_nxt     = plain_state;
                            res_count     = 2'd1;
                            res0.out_byte = oct_accum;
                        end else begin
                            state_nxt.accum       = oct_accum;
                            state_nxt.digit_count = oct_count;
                        end
                    end else begin
                        // Emit the value, then handle the byte as plain text.
                        res0.out_byte = state_cur.accum;
                        if (in_byte == CHAR_BSL) begin
                            state_nxt      = plain_state;
                            state_nxt.mode = MODE_BSL;
                            res_count      = 2'd1;
                        end else begin
                            state_nxt        = plain_state;
                            res_count        = 2'd2;
                            res0.last_of_run = 1'b0;
                        end
                    end
                end
                MODE_HEX: begin
                    if (is_hex) begin
                        state_nxt.accum = {state_cur.accum[3:0], hex_val};
                        if (state_cur.digit_count < HEX_DIGITS) begin
                            state_nxt.digit_count = state_cur.digit_count + 2'd1;
                        end
                    end else begin
                        res0.out_byte = pending;
                        if (in_byte == CHAR_BSL) begin
                            state_nxt      = plain_state;
                            state_nxt.mode = MODE_BSL;
                            res_count      = 2'd1;
                        end else begin
                            state_nxt        = plain_state;
                            res_count        = 2'd2;
                            res0.last_of_run = 1'b0;
                        end
                    end
                end
                default: begin
                    state_nxt = plain_state;
                end
            endcase
        end
    end

endmodule

/* src/sed_out_queue.sv */
// ----------------------------------------------------------------------------
// sed_out_queue: result queue
// Small register queue that takes up to two results in one cycle and
// presents one result transfer per cycle on the master side while m_tready is high.
// ----------------------------------------------------------------------------
module sed_out_queue
    import sed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_count,
    input  result_t    push0,
    input  result_t    push1,
    output logic       room_for_two,
    output logic       m_tvalid,
    input  logic       m_tready,
    output result_t    head
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    result_t           mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]       count_reg, count_next;
    logic                pop;

    assign m_tvalid     = (count_reg != '0);
    assign pop          = m_tvalid && m_tready;
    assign head         = mem_reg[rd_ptr_reg];
    assign room_for_two = (count_reg <= CW'(QUEUE_DEPTH - 2));

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push_count);
        rd_ptr_next = rd_ptr_reg + QUEUE_AW'(pop);
        count_next  = count_reg + CW'(push_count) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes; the second result goes to the following slot.
    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            mem_reg[wr_ptr_reg + QUEUE_AW'(1)] <= push1;
        end
    end

endmodule

/* src/string_escape_decoder.sv */
// ----------------------------------------------------------------------------
// string_escape_decoder: C-style backslash escape decoder
// Turns a byte stream with backslash escapes into decoded bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel takes one transfer per source byte: s_tdata holds the
//   byte and s_tuser is 0 for a data byte, 1 for end of string. The master
//   channel gives the decoded bytes; m_tuser is 1 for a data byte and 0 for
//   the terminator that closes each string, and m_tlast marks the final
//   result caused by one input transfer. An input transfer gives zero, one
//   or two results.
//   Path: an accepted transfer is held in the input register, is decoded
//   into the result queue once the queue has room for two results, and its
//   first result is then offered on the master side from the queue.
//   Throughput: one input transfer per cycle while each gives at most one
//   result; the master side moves one result per cycle, so a transfer that
//   gives two results slows the input side. The four-entry result queue
//   sets this: an item is decoded only when two slots are free.
//   When the receiver stalls the queue fills and s_tready drops; nothing is
//   lost. Reset returns the decoder to plain text and empties the queue.
// ----------------------------------------------------------------------------
module string_escape_decoder
    import sed_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tuser,   // [0] action
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] is_data
    output logic       m_tlast
);

    logic       in_valid_reg;
    logic       in_action_reg;
    logic [7:0] in_byte_reg;
    dec_state_t state_reg, state_next;
    logic [1:0] res_count;
    logic [1:0] push_count;
    result_t    res0, res1, head;
    logic       room_for_two;
    logic       advance;

    // The held item is decoded when the queue can take both possible results.
    assign advance  = in_valid_reg && room_for_two;
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_action_reg <= s_tuser;
            in_byte_reg   <= s_tdata;
        end
    end

    sed_decode u_decode (
        .state_cur (state_reg),
        .action    (in_action_reg),
        .in_byte   (in_byte_reg),
        .state_nxt (state_next),
        .res_count (res_count),
        .res0      (res0),
        .res1      (res1)
    );

    // Decoder state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{mode: MODE_PLAIN, accum: 8'd0, digit_count: 2'd0};
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    assign push_count = advance ? res_count : 2'd0;

    sed_out_queue u_queue (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .push_count   (push_count),
        .push0        (res0),
        .push1        (res1),
        .room_for_two (room_for_two),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .head         (head)
    );

    assign m_tdata = head.out_byte;
    assign m_tuser = head.is_data;
    assign m_tlast = head.last_of_run;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the string escape decoder
// Sends source bytes and end-of-string transfers through the slave channel
// and compares every master transfer with the bytes that a behavioral copy
// of the decoder expects. The directed table covers the extremes and the
// escape corner cases first; the random part then sends runs of plain text,
// simple, octal and hex escapes, unknown escapes and flushes. Both channels
// idle at random.
// ----------------------------------------------------------------------------
module tb_top;
    import sed_pkg::*;

    localparam int RAND_ITEMS = 800;
    localparam int IDLE_LIMIT = 2000;
    localparam int PRED       = -1;
    localparam logic [7:0] CHAR_DQ = 8'h22;
    localparam logic [7:0] CHAR_SQ = 8'h27;
    localparam logic [7:0] CHAR_QM = 8'h3f;
    localparam result_t NO_RES = '0;

    // Bytes that mean something after a backslash.
    localparam logic [7:0] ESC_CHARS [11] = '{CHAR_A, CHAR_B, CHAR_T, CHAR_N, CHAR_V,
        CHAR_F, CHAR_R, CHAR_DQ, CHAR_SQ, CHAR_BSL, CHAR_QM};

    typedef struct packed {
        logic       act;
        logic [7:0] data;
    } src_item_t;

    // One directed row; n_typed is the number of typed results, or PRED.
    typedef struct {
        logic       act;
        logic [7:0] data;
        int         n_typed;
        result_t    r0;
        result_t    r1;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    dir_row_t dir_table [DIR_ROWS] = '{
        // End of string right after reset gives the terminator alone.
        '{ACT_FLUSH, 8'h00,   1, '{8'h00, 1'b0, 1'b1}, NO_RES},
        '{ACT_DATA,  8'hff,   1, '{8'hff, 1'b1, 1'b1}, NO_RES},
        '{ACT_DATA,  CHAR_BSL, 0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_N,  1, '{CODE_LF, 1'b1, 1'b1}, NO_RES},
        // Unknown escape of a non-ASCII byte gives the byte itself.
        '{ACT_DATA,  CHAR_BSL, 0, NO_RES, NO_RES},
        '{ACT_DATA,  8'hff,   1, '{8'hff, 1'b1, 1'b1}, NO_RES},
        // Three octal digits close the escape; 0777 wraps to 0xff.
        '{ACT_DATA,  CHAR_BSL, 0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_7,  0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_7,  0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_7,  1, '{8'hff, 1'b1, 1'b1}, NO_RES},
        // Octal ended by a backslash, which opens a new escape.
        '{ACT_DATA,  CHAR_BSL, 0, NO_RES, NO_RES},
        '{ACT_DATA,  8'h34,   0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_BSL, 1, '{8'h04, 1'b1, 1'b1}, NO_RES},
        '{ACT_DATA,  8'h7a,   1, '{8'h7a, 1'b1, 1'b1}, NO_RES},
        // Hex keeps its last two digits, then the ending byte follows.
        '{ACT_DATA,  CHAR_BSL, 0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_X,  0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_UF, 0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_LF, 0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_UA, 0, NO_RES, NO_RES},
        '{ACT_DATA,  8'h67,   PRED, NO_RES, NO_RES},
        // Hex escape without digits flushed at end of string gives 'x'.
        '{ACT_DATA,  CHAR_BSL, 0, NO_RES, NO_RES},
        '{ACT_DATA,  CHAR_X,  0, NO_RES, NO_RES},
        '{ACT_FLUSH, 8'hff,   2, '{CHAR_X, 1'b1, 1'b0}, '{8'h00, 1'b0, 1'b1}},
        // A lone trailing backslash is dropped.
        '{ACT_DATA,  CHAR_BSL, 0, NO_RES, NO_RES},
        '{ACT_FLUSH, 8'h5c,   1, '{8'h00, 1'b0, 1'b1}, NO_RES}
    };

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // [7:0] in_byte
    logic       s_tuser  = 1'b0;    // [0] action
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // [7:0] out_byte
    logic       m_tuser;            // [0] is_data
    logic       m_tlast;

    // Decoder copy used to predict the output.
    mode_t      dec_mode = MODE_PLAIN;
    logic [7:0] dec_acc  = 8'h00;
    logic [1:0] dec_cnt  = 2'd0;

    result_t    decoded_q [$];
    src_item_t  feed_q [$];
    int         errors      = 0;
    int         idle_cycles = 0;
    int         rx_stall    = 0;
    int         calm_left   = 0;
    bit         calm        = 1'b0;

    string_escape_decoder DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Idle length: none in calm stretches, otherwise mostly short.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void clear_decoder();
        dec_mode = MODE_PLAIN;
        dec_acc  = 8'h00;
        dec_cnt  = 2'd0;
    endfunction

    function automatic int hex_nibble(input logic [7:0] c);
        if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
        if (c >= CHAR_LA && c <= CHAR_LF) return int'(c - CHAR_LA) + 10;
        if (c >= CHAR_UA && c <= CHAR_UF) return int'(c - CHAR_UA) + 10;
        return -1;
    endfunction

    // Decodes one input transfer and returns the number of bytes it gives.
    function automatic int decode_escape(input logic act, input logic [7:0] c,
                                         output result_t first, output result_t second);
        result_t    res [2];
        int         n;
        int         h;
        bit         reissue;
        logic [7:0] r;
        logic [7:0] pend;
        n = 0;
        reissue = 1'b0;
        res[0] = NO_RES;
        res[1] = NO_RES;
        pend = (dec_mode == MODE_HEX && dec_cnt == 2'd0) ? CHAR_X : dec_acc;
        if (act == ACT_FLUSH) begin
            if (dec_mode == MODE_OCT || dec_mode == MODE_HEX) begin
                res[n] = '{pend, 1'b1, 1'b0};
                n++;
            end
            res[n] = '{8'h00, 1'b0, 1'b0};
            n++;
            clear_decoder();
        end else begin
            case (dec_mode)
                MODE_BSL: begin
                    case (c)
                        CHAR_A:  r = CODE_BEL;
                        CHAR_B:  r = CODE_BS;
                        CHAR_T:  r = CODE_HT;
                        CHAR_N:  r = CODE_LF;
                        CHAR_V:  r = CODE_VT;
                        CHAR_F:  r = CODE_FF;
                        CHAR_R:  r = CODE_CR;
                        default: r = c;
                    endcase
                    if (c == CHAR_X) begin
                        dec_mode = MODE_HEX;
                        dec_acc  = 8'h00;
                        dec_cnt  = 2'd0;
                    end else if (c >= CHAR_0 && c <= CHAR_7) begin
                        dec_mode = MODE_OCT;
                        dec_acc  = {5'b0, c[2:0]};
                        dec_cnt  = 2'd1;
                    end else begin
                        res[0] = '{r, 1'b1, 1'b0};
                        n = 1;
                        clear_decoder();
                    end
                end
                MODE_OCT: begin
                    if (c >= CHAR_0 && c <= CHAR_7) begin
                        dec_acc = {dec_acc[4:0], c[2:0]};
                        dec_cnt = dec_cnt + 2'd1;
                        if (dec_cnt == OCT_DIGITS) begin
                            res[0] = '{dec_acc, 1'b1, 1'b0};
                            n = 1;
                            clear_decoder();
                        end
                    end else begin
                        res[0] = '{dec_acc, 1'b1, 1'b0};
                        n = 1;
                        clear_decoder();
                        reissue = 1'b1;
                    end
                end
                MODE_HEX: begin
                    h = hex_nibble(c);
                    if (h >= 0) begin
                        dec_acc = {dec_acc[3:0], h[3:0]};
                        if (dec_cnt < HEX_DIGITS) dec_cnt = dec_cnt + 2'd1;
                    end else begin
                        res[0] = '{pend, 1'b1, 1'b0};
                        n = 1;
                        clear_decoder();
                        reissue = 1'b1;
                    end
                end
                default: reissue = 1'b1;
            endcase
            // Plain text, including the byte that closed an escape.
            if (reissue) begin
                if (c == CHAR_BSL) begin
                    dec_mode = MODE_BSL;
                end else begin
                    res[n] = '{c, 1'b1, 1'b0};
                    n++;
                end
            end
        end
        if (n > 0) res[n - 1].last_of_run = 1'b1;
        first  = res[0];
        second = res[1];
        return n;
    endfunction

    // Offers one transfer and holds it until the decoder takes it.
    task automatic send_item(input logic act, input logic [7:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return CHAR_0 + 8'(v);
        return ($urandom_range(0, 1) ? CHAR_LA : CHAR_UA) + 8'(v - 10);
    endfunction

    // Ending of an octal or hex run: nothing, a random byte, a backslash or a flush.
    function automatic void push_escape_end();
        case ($urandom_range(0, 3))
            0: ;
            1: feed_q.push_back('{ACT_DATA, 8'($urandom_range(0, 255))});
            2: feed_q.push_back('{ACT_DATA, CHAR_BSL});
            default: feed_q.push_back('{ACT_FLUSH, 8'($urandom_range(0, 255))});
        endcase
    endfunction

    // Alternating calm stretches without any idling on either side.
    always @(posedge aclk) begin
        if (calm_left == 0) begin
            calm      <= ($urandom_range(0, 3) == 0);
            calm_left <= $urandom_range(50, 300);
        end else begin
            calm_left <= calm_left - 1;
        end
    end

    // Receiver stalls.
    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_tready <= 1'b1;
            rx_stall <= pick_gap();
        end
    end

    // Compare each result transfer with the oldest expected byte.
    always @(posedge aclk) begin : check_results
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (decoded_q.size() == 0) begin
                $error("unexpected result: out_byte %02h is_data %0b last_of_run %0b",
                       m_tdata, m_tuser, m_tlast);
                errors++;
            end else begin
                want = decoded_q.pop_front();
                if (m_tdata !== want.out_byte) begin
                    $error("out_byte: expected %02h, got %02h", want.out_byte, m_tdata);
                    errors++;
                end
                if (m_tuser !== want.is_data) begin
                    $error("is_data: expected %0b, got %0b", want.is_data, m_tuser);
                    errors++;
                end
                if (m_tlast !== want.last_of_run) begin
                    $error("last_of_run: expected %0b, got %0b", want.last_of_run, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        result_t   r0;
        result_t   r1;
        src_item_t it;
        int        n;
        int        k;

        // Random runs, mostly well-formed escapes with random content.
        while (feed_q.size() < RAND_ITEMS) begin
            n = $urandom_range(0, 99);
            if (n < 30) begin
                feed_q.push_back('{ACT_DATA, 8'($urandom_range(0, 255))});
            end else if (n < 45) begin
                feed_q.push_back('{ACT_DATA, CHAR_BSL});
                feed_q.push_back('{ACT_DATA, ESC_CHARS[$urandom_range(0, 10)]});
            end else if (n < 60) begin
                feed_q.push_back('{ACT_DATA, CHAR_BSL});
                repeat ($urandom_range(1, 4))
                    feed_q.push_back('{ACT_DATA, CHAR_0 + 8'($urandom_range(0, 7))});
                push_escape_end();
            end else if (n < 78) begin
                feed_q.push_back('{ACT_DATA, CHAR_BSL});
                feed_q.push_back('{ACT_DATA, CHAR_X});
                repeat ($urandom_range(0, 4)) feed_q.push_back('{ACT_DATA, rand_hex_char()});
                push_escape_end();
            end else if (n < 85) begin
                feed_q.push_back('{ACT_DATA, CHAR_BSL});
                feed_q.push_back('{ACT_DATA, 8'($urandom_range(0, 255))});
            end else if (n < 92) begin
                feed_q.push_back('{ACT_FLUSH, 8'($urandom_range(0, 255))});
            end else begin
                repeat ($urandom_range(1, 4))
                    feed_q.push_back('{1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))});
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed table; typed rows carry their own expected bytes.
        // Expected bytes are queued before the transfer is offered, so they
        // are in place however long the sender idles afterwards.
        for (k = 0; k < DIR_ROWS; k++) begin
            n = decode_escape(dir_table[k].act, dir_table[k].data, r0, r1);
            if (dir_table[k].n_typed != PRED) begin
                n  = dir_table[k].n_typed;
                r0 = dir_table[k].r0;
                r1 = dir_table[k].r1;
            end
            if (n > 0) decoded_q.push_back(r0);
            if (n > 1) decoded_q.push_back(r1);
            send_item(dir_table[k].act, dir_table[k].data);
        end

        // Random part.
        while (feed_q.size() > 0) begin
            it = feed_q.pop_front();
            n = decode_escape(it.act, it.data, r0, r1);
            if (n > 0) decoded_q.push_back(r0);
            if (n > 1) decoded_q.push_back(r1);
            send_item(it.act, it.data);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the pipeline latency for stray transfers.
        while (decoded_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
